### rtl/thumbstick_deadzone_filter_defines.svh
// Assertion macros for the thumbstick deadzone filter
`ifndef THUMBSTICK_DEADZONE_FILTER_DEFINES_SVH
`define THUMBSTICK_DEADZONE_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define TDF_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define TDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TDF_ASSERT(label, clk, rst, ante, cons, msg)
`define TDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/tdf_pkg.sv
package tdf_pkg;

   localparam int AXIS_W      = 16;
   localparam int REG_W       = 15;
   localparam int LANE_STAGES = 17;
   localparam int LAST_STAGE  = LANE_STAGES - 1;

   localparam logic [REG_W-1:0] FULL_SCALE   = 15'h7FFF;
   localparam logic [REG_W-1:0] INNER_RESET  = 15'd4095;
   localparam logic [REG_W-1:0] OUTER_RESET  = 15'd30309;

   localparam logic [0:0] REG_DEADZONE_INNER = 1'b0;
   localparam logic [0:0] REG_DEADZONE_OUTER = 1'b1;

   typedef struct packed {
      logic [REG_W-1:0] inner;
      logic [REG_W-1:0] outer;
   } cfg_type;

   // restoring divider state, 16 quotient bits
   typedef struct packed {
      logic [23:0] rem;
      logic [15:0] low;
      logic [15:0] q;
   } div_type;

   // digit-by-digit square root state, 48-bit radicand
   typedef struct packed {
      logic [47:0] rad;
      logic [24:0] rem;
      logic [23:0] root;
   } sqrt_type;

   typedef struct packed {
      logic        neg_x;
      logic        neg_y;
      logic [15:0] mag_x;
      logic [15:0] mag_y;
      logic [30:0] sq_x;
      logic [30:0] sq_y;
      logic        zero_x;
      logic        full_x;
      logic        zero_y;
      logic        full_y;
      div_type     div_x;
      div_type     div_y;
      sqrt_type    sq;
      logic [23:0] len;
      logic        r_zero;
      logic        r_full;
      div_type     rate_div;
      logic [38:0] prod_x;
      logic [38:0] prod_y;
      div_type     rad_x;
      div_type     rad_y;
   } lane_stage_type;

   typedef struct packed {
      logic [15:0] axis_x;
      logic [15:0] axis_y;
      logic [15:0] radial_x;
      logic [15:0] radial_y;
      logic        active;
   } lane_result_type;

   function automatic div_type div_init(input logic [39:0] num);
      div_type r;
      r.rem = num[39:16];
      r.low = num[15:0];
      r.q   = '0;
      return r;
   endfunction

   function automatic div_type div_step(input div_type d, input logic [23:0] den);
      div_type     r;
      logic [24:0] t;
      t     = {d.rem, d.low[15]};
      r.low = {d.low[14:0], 1'b0};
      if (t >= {1'b0, den}) begin
         r.rem = 24'(t - {1'b0, den});
         r.q   = {d.q[14:0], 1'b1};
      end else begin
         r.rem = t[23:0];
         r.q   = {d.q[14:0], 1'b0};
      end
      return r;
   endfunction

   function automatic sqrt_type sqrt_step(input sqrt_type s);
      sqrt_type    r;
      logic [26:0] t;
      logic [26:0] trial;
      t     = {s.rem, s.rad[47:46]};
      trial = {1'b0, s.root, 2'b01};
      r.rad = {s.rad[45:0], 2'b00};
      if (t >= trial) begin
         r.rem  = 25'(t - trial);
         r.root = {s.root[22:0], 1'b1};
      end else begin
         r.rem  = t[24:0];
         r.root = {s.root[22:0], 1'b0};
      end
      return r;
   endfunction

   // x * 32767 as a shift and subtract
   function automatic logic [39:0] times_full(input logic [23:0] x);
      return 40'({x, 15'b0}) - 40'(x);
   endfunction

   function automatic logic [15:0] apply_sign(input logic neg, input logic [14:0] m);
      logic [15:0] v;
      v = {1'b0, m};
      return neg ? (~v + 16'd1) : v;
   endfunction

endpackage

### rtl/tdf_req_if.sv
interface tdf_req_if import tdf_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [AXIS_W-1:0] left_x;
   logic signed [AXIS_W-1:0] left_y;
   logic signed [AXIS_W-1:0] right_x;
   logic signed [AXIS_W-1:0] right_y;
   modport source(output valid, left_x, left_y, right_x, right_y, input ready);
   modport sink(input valid, left_x, left_y, right_x, right_y, output ready);
endinterface

### rtl/tdf_rsp_if.sv
interface tdf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_axis_x;
   logic signed [15:0] left_axis_y;
   logic signed [15:0] left_radial_x;
   logic signed [15:0] left_radial_y;
   logic               left_active;
   logic signed [15:0] right_axis_x;
   logic signed [15:0] right_axis_y;
   logic signed [15:0] right_radial_x;
   logic signed [15:0] right_radial_y;
   logic               right_active;
   modport source(output valid, left_axis_x, left_axis_y, left_radial_x, left_radial_y,
                  left_active, right_axis_x, right_axis_y, right_radial_x,
                  right_radial_y, right_active, input ready);
   modport sink(input valid, left_axis_x, left_axis_y, left_radial_x, left_radial_y,
                left_active, right_axis_x, right_axis_y, right_radial_x,
                right_radial_y, right_active, output ready);
endinterface

### rtl/tdf_csr_if.sv
interface tdf_csr_if import tdf_pkg::*;;
   logic             valid;
   logic             ready;
   logic [0:0]       index;
   logic [REG_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

### rtl/tdf_stick_lane.sv
module tdf_stick_lane import tdf_pkg::*; (
   input  logic                     clock,
   input  logic                     advance,
   input  cfg_type                  cfg,
   input  logic signed [AXIS_W-1:0] in_x,
   input  logic signed [AXIS_W-1:0] in_y,
   output lane_result_type          result
);

   lane_stage_type pipe_ff [LANE_STAGES];
   lane_stage_type pipe_in [LANE_STAGES];

   logic [15:0] inner16;
   logic [15:0] outer16;
   logic [23:0] in8;
   logic [23:0] out8;
   logic [23:0] den_axis;
   logic [23:0] den_rate;

   assign inner16  = {1'b0, cfg.inner};
   assign outer16  = {1'b0, cfg.outer};
   assign in8      = {1'b0, cfg.inner, 8'b0};
   assign out8     = {1'b0, cfg.outer, 8'b0};
   assign den_axis = 24'(cfg.outer - cfg.inner);
   assign den_rate = {1'b0, 15'(cfg.outer - cfg.inner), 8'b0};

   // capture: magnitudes, squares, axis deadzone flags and divider setup
   always_comb begin
      lane_stage_type nxt;
      nxt        = '0;
      nxt.neg_x  = in_x[15];
      nxt.neg_y  = in_y[15];
      nxt.mag_x  = in_x[15] ? (~in_x + 16'd1) : in_x;
      nxt.mag_y  = in_y[15] ? (~in_y + 16'd1) : in_y;
      nxt.sq_x   = 31'(nxt.mag_x * nxt.mag_x);
      nxt.sq_y   = 31'(nxt.mag_y * nxt.mag_y);
      nxt.zero_x = (nxt.mag_x == 16'd0) || (nxt.mag_x < inner16);
      nxt.zero_y = (nxt.mag_y == 16'd0) || (nxt.mag_y < inner16);
      nxt.full_x = nxt.mag_x >= outer16;
      nxt.full_y = nxt.mag_y >= outer16;
      nxt.div_x  = div_init(times_full(24'(nxt.mag_x - inner16)));
      nxt.div_y  = div_init(times_full(24'(nxt.mag_y - inner16)));
      pipe_in[0] = nxt;
   end

   for (genvar k = 1; k < LANE_STAGES; k++) begin : g_stage
      always_comb begin
         lane_stage_type nxt;
         logic [14:0]    rate;
         nxt  = pipe_ff[k-1];
         rate = '0;
         if (k == 1) begin
            nxt.sq.rad  = {32'(nxt.sq_x) + 32'(nxt.sq_y), 16'b0};
            nxt.sq.rem  = '0;
            nxt.sq.root = '0;
         end
         if (k <= 4) begin
            for (int i = 0; i < 4; i++) begin
               nxt.div_x = div_step(nxt.div_x, den_axis);
               nxt.div_y = div_step(nxt.div_y, den_axis);
            end
         end
         if (k <= 6) begin
            for (int i = 0; i < 4; i++) begin
               nxt.sq = sqrt_step(nxt.sq);
            end
         end
         if (k == 7) begin
            nxt.len      = nxt.sq.root;
            nxt.r_zero   = (nxt.len == 24'd0) || (nxt.len < in8);
            nxt.r_full   = nxt.len >= out8;
            nxt.rate_div = div_init(times_full(nxt.len - in8));
         end
         if (k >= 8 && k <= 11) begin
            for (int i = 0; i < 4; i++) begin
               nxt.rate_div = div_step(nxt.rate_div, den_rate);
            end
         end
         if (k == 12) begin
            rate       = nxt.r_full ? FULL_SCALE : nxt.rate_div.q[14:0];
            nxt.prod_x = {15'b0, nxt.mag_x, 8'b0} * {24'b0, rate};
            nxt.prod_y = {15'b0, nxt.mag_y, 8'b0} * {24'b0, rate};
         end
         if (k == 13) begin
            nxt.rad_x = div_init({1'b0, nxt.prod_x});
            nxt.rad_y = div_init({1'b0, nxt.prod_y});
         end
         if (k >= 13) begin
            for (int i = 0; i < 4; i++) begin
               nxt.rad_x = div_step(nxt.rad_x, nxt.len);
               nxt.rad_y = div_step(nxt.rad_y, nxt.len);
            end
         end
         pipe_in[k] = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < LANE_STAGES; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   always_comb begin
      lane_stage_type p;
      logic [14:0]    rq_x;
      logic [14:0]    rq_y;
      p    = pipe_ff[LAST_STAGE];
      rq_x = p.r_zero ? 15'd0 : p.rad_x.q[14:0];
      rq_y = p.r_zero ? 15'd0 : p.rad_y.q[14:0];
      result.axis_x   = p.zero_x ? 16'd0 :
                        apply_sign(p.neg_x, p.full_x ? FULL_SCALE : p.div_x.q[14:0]);
      result.axis_y   = p.zero_y ? 16'd0 :
                        apply_sign(p.neg_y, p.full_y ? FULL_SCALE : p.div_y.q[14:0]);
      result.radial_x = apply_sign(p.neg_x, rq_x);
      result.radial_y = apply_sign(p.neg_y, rq_y);
      result.active   = (rq_x != 15'd0) || (rq_y != 15'd0);
   end

endmodule

### rtl/thumbstick_deadzone_filter.sv
// Thumbstick deadzone filter.
// req_ch carries one gamepad sample (both sticks, signed 16-bit axes); rsp_ch
// returns per-axis deadzone results and the radial deadzone of each stick,
// Q1.15 scaled by 32767. csr_ch writes deadzone_inner (index 0) and
// deadzone_outer (index 1); it is always ready and must only be used while no
// sample is in flight.
// Each stick runs in its own lane: a 17-stage pipeline with square root and
// restoring dividers retiring 4 bits per stage, followed by one merge register.
// A result is valid once the sample has passed the lane stages and the merge register.
// Throughput: one sample per cycle from the fully pipelined lanes unless stalled.
// Reset clears all valid flags and loads inner 4095 and outer 30309.
// When rsp_ch stalls with a result pending, the whole pipeline holds and
// req_ch.ready drops; no sample is lost or duplicated.
`include "thumbstick_deadzone_filter_defines.svh"
module thumbstick_deadzone_filter import tdf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tdf_req_if.sink   req_ch,
   tdf_rsp_if.source rsp_ch,
   tdf_csr_if.sink   csr_ch
);

   cfg_type               cfg_ff;
   logic [LAST_STAGE:0]   valid_ff;
   logic [LAST_STAGE:0]   valid_in;
   logic                  rsp_valid_ff;
   lane_result_type       rsp_left_ff;
   lane_result_type       rsp_right_ff;
   lane_result_type       left_result;
   lane_result_type       right_result;
   logic                  advance;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign csr_ch.ready = 1'b1;
   assign valid_in     = {valid_ff[LAST_STAGE-1:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inner <= INNER_RESET;
         cfg_ff.outer <= OUTER_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_DEADZONE_INNER: cfg_ff.inner <= csr_ch.data;
            REG_DEADZONE_OUTER: cfg_ff.outer <= csr_ch.data;
            default: ;
         endcase
      end
   end

   tdf_stick_lane u_left (
      .clock   (clock),
      .advance (advance),
      .cfg     (cfg_ff),
      .in_x    (req_ch.left_x),
      .in_y    (req_ch.left_y),
      .result  (left_result)
   );

   tdf_stick_lane u_right (
      .clock   (clock),
      .advance (advance),
      .cfg     (cfg_ff),
      .in_x    (req_ch.right_x),
      .in_y    (req_ch.right_y),
      .result  (right_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[LAST_STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_left_ff  <= left_result;
         rsp_right_ff <= right_result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.left_axis_x    = rsp_left_ff.axis_x;
   assign rsp_ch.left_axis_y    = rsp_left_ff.axis_y;
   assign rsp_ch.left_radial_x  = rsp_left_ff.radial_x;
   assign rsp_ch.left_radial_y  = rsp_left_ff.radial_y;
   assign rsp_ch.left_active    = rsp_left_ff.active;
   assign rsp_ch.right_axis_x   = rsp_right_ff.axis_x;
   assign rsp_ch.right_axis_y   = rsp_right_ff.axis_y;
   assign rsp_ch.right_radial_x = rsp_right_ff.radial_x;
   assign rsp_ch.right_radial_y = rsp_right_ff.radial_y;
   assign rsp_ch.right_active   = rsp_right_ff.active;

   `TDF_ASSERT(a_left_active, clock, reset, rsp_valid_ff, rsp_left_ff.active == ((rsp_left_ff.radial_x != 16'd0) || (rsp_left_ff.radial_y != 16'd0)), "left active flag mismatch")
   `TDF_ASSERT(a_right_active, clock, reset, rsp_valid_ff, rsp_right_ff.active == ((rsp_right_ff.radial_x != 16'd0) || (rsp_right_ff.radial_y != 16'd0)), "right active flag mismatch")
   `TDF_ASSERT(a_axis_range, clock, reset, rsp_valid_ff, (rsp_left_ff.axis_x != 16'h8000) && (rsp_right_ff.axis_x != 16'h8000), "axis result beyond full scale")
   `TDF_ASSERT_NEXT(a_drain, clock, reset, valid_ff[LAST_STAGE] && advance, rsp_valid_ff, "finished sample did not reach output")

endmodule

### tb/sv/thumbstick_deadzone_filter_test.sv
module thumbstick_deadzone_filter_test;
   import tdf_pkg::*;

   typedef struct {
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] radial_x;
      logic signed [15:0] radial_y;
      logic               active;
   } stick_out_type;

   typedef struct {
      stick_out_type left;
      stick_out_type right;
   } sample_out_type;

   class deadzone_scoreboard;
      longint         inner;
      longint         outer;
      sample_out_type pending[$];
      int             errors;
      int             mismatches;
      int             checked;

      function new();
         inner = INNER_RESET;
         outer = OUTER_RESET;
         errors = 0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void set_reg(logic [0:0] idx, logic [REG_W-1:0] val);
         if (idx == REG_DEADZONE_INNER) inner = val;
         else outer = val;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function logic signed [15:0] axis_deadzone(logic signed [15:0] a);
         longint v;
         longint mag;
         longint r;
         v = a;
         mag = v < 0 ? -v : v;
         if (v == 0 || mag < inner) return 16'sd0;
         if (mag >= outer) r = 32767;
         else r = ((mag - inner) * 32767) / (outer - inner);
         return v < 0 ? 16'(-r) : 16'(r);
      endfunction

      function stick_out_type stick_deadzone(logic signed [15:0] x, logic signed [15:0] y);
         stick_out_type   o;
         longint          vx;
         longint          vy;
         longint unsigned ax;
         longint unsigned ay;
         longint unsigned len8;
         longint unsigned in8;
         longint unsigned out8;
         longint unsigned rate;
         longint          rx;
         longint          ry;
         vx = x;
         vy = y;
         ax = vx < 0 ? -vx : vx;
         ay = vy < 0 ? -vy : vy;
         o.axis_x = axis_deadzone(x);
         o.axis_y = axis_deadzone(y);
         o.radial_x = 0;
         o.radial_y = 0;
         o.active = 0;
         len8 = int_sqrt((ax * ax + ay * ay) << 16);
         in8 = inner << 8;
         out8 = outer << 8;
         if (len8 == 0 || len8 < in8) return o;
         if (len8 >= out8) rate = 32767;
         else rate = ((len8 - in8) * 32767) / (out8 - in8);
         rx = ((ax << 8) * rate) / len8;
         ry = ((ay << 8) * rate) / len8;
         o.active = (rx != 0 || ry != 0);
         if (vx < 0) rx = -rx;
         if (vy < 0) ry = -ry;
         o.radial_x = 16'(rx);
         o.radial_y = 16'(ry);
         return o;
      endfunction

      function void note_sample(logic signed [15:0] lx, logic signed [15:0] ly,
                                logic signed [15:0] rx, logic signed [15:0] ry);
         sample_out_type e;
         e.left = stick_deadzone(lx, ly);
         e.right = stick_deadzone(rx, ry);
         pending.push_back(e);
      endfunction

      function void cmp(string name, longint e, longint a);
         if (e != a) begin
            mismatches++;
            errors++;
            if (mismatches <= 10)
               $display("mismatch on result %0d, %s: expected %0d, got %0d",
                        checked, name, e, a);
         end
      endfunction

      function void check_result(sample_out_type a);
         sample_out_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("result with no sample outstanding");
            return;
         end
         e = pending.pop_front();
         cmp("left_axis_x", e.left.axis_x, a.left.axis_x);
         cmp("left_axis_y", e.left.axis_y, a.left.axis_y);
         cmp("left_radial_x", e.left.radial_x, a.left.radial_x);
         cmp("left_radial_y", e.left.radial_y, a.left.radial_y);
         cmp("left_active", e.left.active, a.left.active);
         cmp("right_axis_x", e.right.axis_x, a.right.axis_x);
         cmp("right_axis_y", e.right.axis_y, a.right.axis_y);
         cmp("right_radial_x", e.right.radial_x, a.right.radial_x);
         cmp("right_radial_y", e.right.radial_y, a.right.radial_y);
         cmp("right_active", e.right.active, a.right.active);
         checked++;
      endfunction
   endclass

   logic clock;
   logic reset;
   tdf_req_if req_ch();
   tdf_rsp_if rsp_ch();
   tdf_csr_if csr_ch();

   thumbstick_deadzone_filter uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_ch(csr_ch.sink)
   );

   deadzone_scoreboard sb = new();
   bit no_gaps;
   bit no_stalls;
   int sent;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.left_x <= '0;
      req_ch.left_y <= '0;
      req_ch.right_x <= '0;
      req_ch.right_y <= '0;
      rsp_ch.ready <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data <= '0;
   end

   task automatic send_sample(logic signed [15:0] lx, logic signed [15:0] ly,
                              logic signed [15:0] rx, logic signed [15:0] ry);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.left_x <= lx;
      req_ch.left_y <= ly;
      req_ch.right_x <= rx;
      req_ch.right_y <= ry;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_sample(lx, ly, rx, ry);
      sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [REG_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      sb.set_reg(idx, val);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_axis();
      longint m;
      int     sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1, 2: return 16'($urandom);
         3: m = sb.inner + $urandom_range(0, 6) - 3;
         4: m = sb.outer + $urandom_range(0, 6) - 3;
         5: m = $urandom_range(0, 8);
         6: m = $urandom_range(32760, 32768);
         default: m = $urandom_range(0, 32767);
      endcase
      if (m < 0) m = 0;
      if (m > 32768) m = 32768;
      return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
   endfunction

   // stick of a chosen length near a threshold, random direction
   task automatic send_radial_near(longint r);
      longint x;
      longint y;
      real    ang;
      ang = $urandom_range(0, 6283) / 1000.0;
      x = longint'(r * $cos(ang));
      y = longint'(r * $sin(ang));
      if (x > 32767) x = 32767;
      if (y > 32767) y = 32767;
      if (x < -32768) x = -32768;
      if (y < -32768) y = -32768;
      send_sample(16'(x), 16'(y), pick_axis(), pick_axis());
   endtask

   always @(posedge clock) begin
      sample_out_type a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a.left.axis_x = rsp_ch.left_axis_x;
         a.left.axis_y = rsp_ch.left_axis_y;
         a.left.radial_x = rsp_ch.left_radial_x;
         a.left.radial_y = rsp_ch.left_radial_y;
         a.left.active = rsp_ch.left_active;
         a.right.axis_x = rsp_ch.right_axis_x;
         a.right.axis_y = rsp_ch.right_axis_y;
         a.right.radial_x = rsp_ch.right_radial_x;
         a.right.radial_y = rsp_ch.right_radial_y;
         a.right.active = rsp_ch.right_active;
         sb.check_result(a);
      end
   end

   initial begin
      int  stall;
      bit  held;
      held = 0;
      @(negedge reset);
      forever begin
         if (!held && sb.checked >= 200) begin
            held = 1;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         stall = no_stalls ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      #3000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      longint inners[8] = '{4095, 0, 0, 32767, 20000, 32767, 8000, 0};
      longint outers[8] = '{30309, 32767, 0, 32767, 500, 0, 20000, 0};
      no_gaps = 0;
      no_stalls = 0;
      sent = 0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset thresholds first, then directed extremes
      send_sample(-16'sd32768, 16'sd32767, 16'sd0, 16'sd0);
      send_sample(16'sd0, 16'sd0, -16'sd32768, -16'sd32768);
      send_sample(16'sd32767, 16'sd32767, 16'sd1, -16'sd1);
      send_sample(16'sd4095, -16'sd4095, 16'sd4094, -16'sd4094);
      send_sample(16'sd30309, -16'sd30309, 16'sd30308, -16'sd30308);
      send_sample(16'sd3000, 16'sd3000, 16'sd0, 16'sd4095);
      send_sample(16'sd4096, 16'sd1, -16'sd1, 16'sd4096);
      send_sample(16'sd21432, -16'sd21432, 16'sd21431, 16'sd21431);
      drain();

      for (int p = 0; p < 8; p++) begin
         if (p == 7) begin
            inners[p] = $urandom_range(0, 32767);
            outers[p] = $urandom_range(0, 32767);
         end
         write_reg(REG_DEADZONE_INNER, 15'(inners[p]));
         write_reg(REG_DEADZONE_OUTER, 15'(outers[p]));
         no_gaps = (p == 2 || p == 5);
         no_stalls = (p == 2 || p == 6);
         // zero stick and tiny strokes matter when inner is zero
         send_sample(16'sd0, 16'sd0, 16'sd1, 16'sd0);
         send_sample(16'(sb.inner), 16'sd0, 16'(-sb.inner), 16'sd0);
         send_sample(16'(sb.outer), 16'sd0, 16'sd0, 16'(-sb.outer));
         for (int i = 0; i < 125; i++) begin
            if ($urandom_range(0, 3) == 0)
               send_radial_near($urandom_range(0, 1) ? sb.inner : sb.outer);
            else
               send_sample(pick_axis(), pick_axis(), pick_axis(), pick_axis());
         end
         drain();
      end

      $display("%0d samples over 9 threshold settings, %0d results compared, %0d bad fields",
               sent, sb.checked, sb.mismatches);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/tdf_pkg.sv
rtl/tdf_req_if.sv
rtl/tdf_rsp_if.sv
rtl/tdf_csr_if.sv
rtl/tdf_stick_lane.sv
rtl/thumbstick_deadzone_filter.sv
tb/sv/thumbstick_deadzone_filter_test.sv
